// ===== src/brs_pkg.sv =====
package brs_pkg;

   localparam int MAX_SIDE = 128;
   localparam int IDX_W    = $clog2(MAX_SIDE);
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
   localparam int SIDE_W   = 8;
   localparam int PIX_W    = 8;
   localparam int POS_W    = 2 * IDX_W;
   localparam int PROD_W   = PIX_W + IDX_W + 1;
   localparam int ACC_W    = PIX_W + 2 * IDX_W;
   localparam int DSQ_W    = 2 * IDX_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_SIDE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_SIDE   = CSR_IDX_W'(1);

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_COMPUTE = 1'b1;

   localparam logic [SIDE_W-1:0] SOURCE_SIDE_MIN   = SIDE_W'(2);
   localparam logic [SIDE_W-1:0] DEST_SIDE_MIN     = SIDE_W'(1);
   localparam logic [SIDE_W-1:0] SIDE_MAX          = SIDE_W'(MAX_SIDE);
   localparam logic [SIDE_W-1:0] SOURCE_SIDE_RESET = SIDE_W'(128);
   localparam logic [SIDE_W-1:0] DEST_SIDE_RESET   = SIDE_W'(64);

   // One queued transaction: a pixel load, or a compute with its scaled positions.
   typedef struct packed {
      logic              action;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [PIX_W-1:0]  pixel;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
   } brs_item_type;

   typedef struct packed {
      logic         push;
      brs_item_type item;
   } brs_enq_type;

   typedef struct packed {
      logic full;
      logic empty;
   } brs_qstat_type;

endpackage

// ===== src/brs_front.sv =====
module brs_front (
   input  logic                          req_valid,
   input  logic                          req_action,
   input  logic [brs_pkg::IDX_W-1:0]     req_row_index,
   input  logic [brs_pkg::IDX_W-1:0]     req_col_index,
   input  logic [brs_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                          req_stall,
   input  logic [brs_pkg::SIDE_W-1:0]    source_side,
   input  logic [brs_pkg::SIDE_W-1:0]    dest_side,
   input  brs_pkg::brs_qstat_type        qstat,
   output brs_pkg::brs_enq_type          enq
);

   logic [brs_pkg::SIDE_W-1:0] span;
   logic [brs_pkg::IDX_W-1:0]  span_n;
   logic                       inside_dest;

   // Computes outside the destination image are taken and dropped here.
   always_comb begin
      span        = source_side - brs_pkg::SIDE_W'(1);
      span_n      = span[brs_pkg::IDX_W-1:0];
      inside_dest = ({1'b0, req_row_index} < dest_side) &&
                    ({1'b0, req_col_index} < dest_side);
      req_stall   = qstat.full;

      enq.item.action = req_action;
      enq.item.row    = req_row_index;
      enq.item.col    = req_col_index;
      enq.item.pixel  = req_pixel_in;
      enq.item.pos_x  = brs_pkg::POS_W'(req_row_index) * brs_pkg::POS_W'(span_n);
      enq.item.pos_y  = brs_pkg::POS_W'(req_col_index) * brs_pkg::POS_W'(span_n);
      enq.push        = req_valid && !qstat.full &&
                        ((req_action == brs_pkg::ACT_LOAD) || inside_dest);
   end

endmodule

// ===== src/brs_queue.sv =====
module brs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  brs_pkg::brs_enq_type   enq,
   input  logic                   pop,
   output brs_pkg::brs_item_type  head,
   output brs_pkg::brs_qstat_type qstat
);

   brs_pkg::brs_item_type entry_ff [brs_pkg::QUEUE_DEPTH];
   logic [brs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [brs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [brs_pkg::QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      qstat.full  = (count_ff == brs_pkg::QCNT_W'(brs_pkg::QUEUE_DEPTH));
      qstat.empty = (count_ff == '0);
      head        = entry_ff[rd_ptr_ff];
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      if (enq.push) begin
         wr_ptr_in = (wr_ptr_ff == brs_pkg::QPTR_W'(brs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + brs_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == brs_pkg::QPTR_W'(brs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + brs_pkg::QPTR_W'(1);
      end
      if (enq.push && !pop) begin
         count_in = count_ff + brs_pkg::QCNT_W'(1);
      end else if (pop && !enq.push) begin
         count_in = count_ff - brs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq.push) begin
         entry_ff[wr_ptr_ff] <= enq.item;
      end
   end

endmodule

// ===== src/brs_back.sv =====
module brs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [brs_pkg::SIDE_W-1:0]    dest_side,
   input  brs_pkg::brs_item_type         head,
   input  brs_pkg::brs_qstat_type        qstat,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brs_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [brs_pkg::IDX_W-1:0]     rsp_out_row,
   output logic [brs_pkg::IDX_W-1:0]     rsp_out_col
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_NORM  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam int IW = brs_pkg::IDX_W;
   localparam int PW = brs_pkg::PIX_W;
   localparam int SW = brs_pkg::SIDE_W;
   localparam int AW = brs_pkg::ACC_W;
   localparam int DW = brs_pkg::DSQ_W;
   localparam int RW = brs_pkg::DSQ_W - 1;

   logic [PW-1:0] mem [brs_pkg::DEPTH];

   logic [2:0]    state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   logic [2:0]    issue_ff, issue_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [1:0]    rd_k_ff, rd_k_in;
   logic          prod_valid_ff, prod_valid_in;
   logic [1:0]    prod_k_ff, prod_k_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0] row_ff, row_in, col_ff, col_in;
   logic [IW-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [IW-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [PW-1:0] rdata_ff;
   logic [brs_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [DW-1:0] dsq_ff, dsq_in;
   logic [RW-1:0] nrem_ff, nrem_in;
   logic [PW-1:0] nq_ff, nq_in;
   logic [PW-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic [IW-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;

   logic                   mem_we, mem_re;
   logic [brs_pkg::ADDR_W-1:0] mem_addr;
   logic [PW-1:0]          mem_wdata;

   logic [IW:0]    trial_x, trial_y;
   logic           ge_x, ge_y;
   logic [SW-1:0]  wx0, wx1, wy0, wy1;
   logic [15:0]    dsq_full;
   logic [23:0]    term;
   logic [DW-1:0]  ntrial;
   logic           nge;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      rd_k_in       = rd_k_ff;
      prod_valid_in = 1'b0;
      prod_k_in     = prod_k_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      row_in        = row_ff;
      col_in        = col_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      dsq_in        = dsq_ff;
      nrem_in       = nrem_ff;
      nq_in         = nq_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_wdata     = head.pixel;
      mem_addr      = {head.row, head.col};

      // Restoring division, one quotient bit of each position a cycle.
      trial_x  = {rx_ff, qx_ff[IW-1]};
      trial_y  = {ry_ff, qy_ff[IW-1]};
      ge_x     = ({1'b0, trial_x} >= {1'b0, dest_side});
      ge_y     = ({1'b0, trial_y} >= {1'b0, dest_side});

      wx1      = {1'b0, rx_ff};
      wy1      = {1'b0, ry_ff};
      wx0      = dest_side - wx1;
      wy0      = dest_side - wy1;
      dsq_full = dest_side * dest_side;
      term     = prod_ff * (prod_k_ff[1] ? wy1 : wy0);

      ntrial   = {nrem_ff, nq_ff[PW-1]};
      nge      = (ntrial >= dsq_ff);

      // Weighting pipeline, driven by its own valid tags.
      if (rd_valid_ff) begin
         prod_valid_in = 1'b1;
         prod_k_in     = rd_k_ff;
         prod_in       = rdata_ff * (rd_k_ff[0] ? wx1 : wx0);
      end
      if (prod_valid_ff) begin
         acc_in = acc_ff + term[AW-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop = 1'b1;
               if (head.action == brs_pkg::ACT_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  row_in   = head.row;
                  col_in   = head.col;
                  rx_in    = head.pos_x[brs_pkg::POS_W-1:IW];
                  qx_in    = head.pos_x[IW-1:0];
                  ry_in    = head.pos_y[brs_pkg::POS_W-1:IW];
                  qy_in    = head.pos_y[IW-1:0];
                  dsq_in   = dsq_full[DW-1:0];
                  acc_in   = '0;
                  issue_in = '0;
                  step_in  = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rx_in   = ge_x ? IW'(trial_x - dest_side) : trial_x[IW-1:0];
            ry_in   = ge_y ? IW'(trial_y - dest_side) : trial_y[IW-1:0];
            qx_in   = {qx_ff[IW-2:0], ge_x};
            qy_in   = {qy_ff[IW-2:0], ge_y};
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(IW - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            mem_addr = {qx_ff + IW'(issue_ff[0]), qy_ff + IW'(issue_ff[1])};
            if (!issue_ff[2]) begin
               mem_re      = 1'b1;
               rd_valid_in = 1'b1;
               rd_k_in     = issue_ff[1:0];
               issue_in    = issue_ff + 3'd1;
            end else if (!rd_valid_ff && !prod_valid_ff) begin
               nrem_in  = acc_ff[AW-1:PW];
               nq_in    = acc_ff[PW-1:0];
               step_in  = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            nrem_in = nge ? RW'(ntrial - dsq_ff) : ntrial[RW-1:0];
            nq_in   = {nq_ff[PW-2:0], nge};
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(PW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = nq_ff;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid     = rsp_valid_ff;
      rsp_pixel_out = rsp_pixel_ff;
      rsp_out_row   = rsp_row_ff;
      rsp_out_col   = rsp_col_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_k_ff      <= rd_k_in;
      prod_k_ff    <= prod_k_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      dsq_ff       <= dsq_in;
      nrem_ff      <= nrem_in;
      nq_ff        <= nq_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

endmodule

// ===== src/bilinear_image_resampler.sv =====
// A compute inside the destination gives one result; loads and other computes give none.
// Computes are taken one at a time: each runs the one-bit-a-cycle position and weight dividers
// (7 and 8 steps) and the four reads of the single-port store; loads drain one per cycle when idle.
// A two-entry queue lets the input side keep accepting while a result waits on the output.
// Reset is synchronous and active high; it clears control state and sets the sides to 128 and 64.
// The pixel store is not cleared: pixels must be loaded before a compute reads them.
module bilinear_image_resampler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_action,
   input  logic [brs_pkg::IDX_W-1:0]        req_row_index,
   input  logic [brs_pkg::IDX_W-1:0]        req_col_index,
   input  logic [brs_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [brs_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic [brs_pkg::IDX_W-1:0]        rsp_out_row,
   output logic [brs_pkg::IDX_W-1:0]        rsp_out_col,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [brs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [brs_pkg::SIDE_W-1:0]       csr_data
);

   // Configuration registers. Written values are saturated into the legal range,
   // and a write to an unknown index is simply ignored.
   logic [brs_pkg::SIDE_W-1:0] source_side_ff, source_side_in;
   logic [brs_pkg::SIDE_W-1:0] dest_side_ff, dest_side_in;

   brs_pkg::brs_enq_type   enq;
   brs_pkg::brs_item_type  head;
   brs_pkg::brs_qstat_type qstat;
   logic                   pop;

   always_comb begin
      csr_ready      = 1'b1;
      source_side_in = source_side_ff;
      dest_side_in   = dest_side_ff;
      if (csr_valid) begin
         case (csr_index)
            brs_pkg::CSR_SOURCE_SIDE: begin
               if (csr_data < brs_pkg::SOURCE_SIDE_MIN) begin
                  source_side_in = brs_pkg::SOURCE_SIDE_MIN;
               end else if (csr_data > brs_pkg::SIDE_MAX) begin
                  source_side_in = brs_pkg::SIDE_MAX;
               end else begin
                  source_side_in = csr_data;
               end
            end
            brs_pkg::CSR_DEST_SIDE: begin
               if (csr_data < brs_pkg::DEST_SIDE_MIN) begin
                  dest_side_in = brs_pkg::DEST_SIDE_MIN;
               end else if (csr_data > brs_pkg::SIDE_MAX) begin
                  dest_side_in = brs_pkg::SIDE_MAX;
               end else begin
                  dest_side_in = csr_data;
               end
            end
            default: begin
               source_side_in = source_side_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_side_ff <= brs_pkg::SOURCE_SIDE_RESET;
         dest_side_ff   <= brs_pkg::DEST_SIDE_RESET;
      end else begin
         source_side_ff <= source_side_in;
         dest_side_ff   <= dest_side_in;
      end
   end

   // The front end sorts each transaction: loads and in-range computes are queued with
   // their scaled source positions, computes outside the destination are dropped.
   brs_front u_front (
      .req_valid     (req_valid),
      .req_action    (req_action),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_pixel_in  (req_pixel_in),
      .req_stall     (req_stall),
      .source_side   (source_side_ff),
      .dest_side     (dest_side_ff),
      .qstat         (qstat),
      .enq           (enq)
   );

   brs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .enq   (enq),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   // The back end owns the pixel store, so loads and computes keep their order.
   brs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .dest_side     (dest_side_ff),
      .head          (head),
      .qstat         (qstat),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col)
   );

endmodule

// ===== sim/bilinear_image_resampler_checker.sv =====
module bilinear_image_resampler_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_action,
   input  logic [brs_pkg::IDX_W-1:0]         req_row_index,
   input  logic [brs_pkg::IDX_W-1:0]         req_col_index,
   input  logic [brs_pkg::PIX_W-1:0]         req_pixel_in,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [brs_pkg::PIX_W-1:0]         rsp_pixel_out,
   input  logic [brs_pkg::IDX_W-1:0]         rsp_out_row,
   input  logic [brs_pkg::IDX_W-1:0]         rsp_out_col,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [brs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [brs_pkg::SIDE_W-1:0]        csr_data,
   output int                                mismatch_count,
   output int                                outstanding_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [brs_pkg::PIX_W-1:0] pixel;
      logic [brs_pkg::IDX_W-1:0] row;
      logic [brs_pkg::IDX_W-1:0] col;
   } resampled_pixel_type;

   logic [brs_pkg::PIX_W-1:0]  image_shadow [brs_pkg::DEPTH];
   logic [brs_pkg::SIDE_W-1:0] source_side_shadow = brs_pkg::SOURCE_SIDE_RESET;
   logic [brs_pkg::SIDE_W-1:0] dest_side_shadow   = brs_pkg::DEST_SIDE_RESET;
   resampled_pixel_type        resampled_q [$];
   int                         errors = 0;

   function automatic logic [brs_pkg::SIDE_W-1:0] saturate_side(
         logic [brs_pkg::SIDE_W-1:0] value, logic [brs_pkg::SIDE_W-1:0] lowest);
      if (value < lowest) return lowest;
      if (value > brs_pkg::SIDE_MAX) return brs_pkg::SIDE_MAX;
      return value;
   endfunction

   // Exact rational position, four-neighbour weighting, floor over D squared.
   function automatic resampled_pixel_type interpolate(logic [brs_pkg::IDX_W-1:0] i,
                                                       logic [brs_pkg::IDX_W-1:0] j);
      longint unsigned d, span, px, py, x, y, rx, ry;
      longint unsigned a, b, c, e, total, level;
      resampled_pixel_type result;
      d     = dest_side_shadow;
      span  = source_side_shadow - 1;
      px    = i * span;
      py    = j * span;
      x     = px / d;
      y     = py / d;
      rx    = px % d;
      ry    = py % d;
      a     = image_shadow[int'(x) * brs_pkg::MAX_SIDE + int'(y)];
      b     = image_shadow[int'(x + 1) * brs_pkg::MAX_SIDE + int'(y)];
      c     = image_shadow[int'(x) * brs_pkg::MAX_SIDE + int'(y + 1)];
      e     = image_shadow[int'(x + 1) * brs_pkg::MAX_SIDE + int'(y + 1)];
      total = a * (d - rx) * (d - ry) + b * rx * (d - ry) + c * ry * (d - rx) + e * rx * ry;
      level = total / (d * d);
      if (level > 255) level = 255;
      result.pixel = level[brs_pkg::PIX_W-1:0];
      result.row   = i;
      result.col   = j;
      return result;
   endfunction

   function automatic void compare_field(string field,
                                         logic [brs_pkg::PIX_W-1:0] expected_value,
                                         logic [brs_pkg::PIX_W-1:0] actual_value);
      if (actual_value !== expected_value) begin
         $error("%s mismatch: expected %0d, actual %0d", field, expected_value, actual_value);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      resampled_pixel_type wanted;
      if (reset) begin
         source_side_shadow = brs_pkg::SOURCE_SIDE_RESET;
         dest_side_shadow   = brs_pkg::DEST_SIDE_RESET;
         resampled_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               brs_pkg::CSR_SOURCE_SIDE:
                  source_side_shadow = saturate_side(csr_data, brs_pkg::SOURCE_SIDE_MIN);
               brs_pkg::CSR_DEST_SIDE:
                  dest_side_shadow   = saturate_side(csr_data, brs_pkg::DEST_SIDE_MIN);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_action == brs_pkg::ACT_LOAD) begin
               image_shadow[{req_row_index, req_col_index}] = req_pixel_in;
            end else if (req_row_index < dest_side_shadow &&
                         req_col_index < dest_side_shadow) begin
               resampled_q.push_back(interpolate(req_row_index, req_col_index));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (resampled_q.size() == 0) begin
               $error("unexpected result: pixel_out %0d, out_row %0d, out_col %0d",
                      rsp_pixel_out, rsp_out_row, rsp_out_col);
               errors++;
            end else begin
               wanted = resampled_q.pop_front();
               compare_field("pixel_out", wanted.pixel, rsp_pixel_out);
               compare_field("out_row", brs_pkg::PIX_W'(wanted.row),
                             brs_pkg::PIX_W'(rsp_out_row));
               compare_field("out_col", brs_pkg::PIX_W'(wanted.col),
                             brs_pkg::PIX_W'(rsp_out_col));
            end
         end
      end
      mismatch_count    <= errors;
      outstanding_count <= resampled_q.size();
   end

endmodule

// ===== sim/bilinear_image_resampler_tb.sv =====
module bilinear_image_resampler_tb ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam realtime HALF_PERIOD     = 5ns;
   localparam int      RESET_CYCLES    = 3;
   // This margin lets the block fall idle before a register write, since loads and computes
   // outside the destination leave nothing to wait for.
   localparam int      SETTLE_CYCLES   = 60;
   localparam int      HOLD_OFF_CYCLES = 400;
   // Longest quiet stretch of a correct run is the hold-off above; the limit is many times that.
   localparam int      WATCHDOG_LIMIT  = 5000;
   localparam int      PHASE_ITEMS     = 92;
   localparam int      FILL_COMPUTES   = 8;

   // Register indexes that the block does not decode.
   localparam logic [brs_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = brs_pkg::CSR_IDX_W'(2);
   localparam logic [brs_pkg::CSR_IDX_W-1:0] CSR_TOP_INDEX   = '1;

   typedef enum {PRESS_NONE, PRESS_PAUSE, PRESS_HOLD_OFF} pressure_type;

   logic                             clock         = 1'b0;
   logic                             reset         = 1'b1;
   logic                             req_valid     = 1'b0;
   logic                             req_stall;
   logic                             req_action    = brs_pkg::ACT_LOAD;
   logic [brs_pkg::IDX_W-1:0]        req_row_index = '0;
   logic [brs_pkg::IDX_W-1:0]        req_col_index = '0;
   logic [brs_pkg::PIX_W-1:0]        req_pixel_in  = '0;
   logic                             rsp_valid;
   logic                             rsp_stall     = 1'b0;
   logic [brs_pkg::PIX_W-1:0]        rsp_pixel_out;
   logic [brs_pkg::IDX_W-1:0]        rsp_out_row;
   logic [brs_pkg::IDX_W-1:0]        rsp_out_col;
   logic                             csr_valid     = 1'b0;
   logic                             csr_ready;
   logic [brs_pkg::CSR_IDX_W-1:0]    csr_index     = '0;
   logic [brs_pkg::SIDE_W-1:0]       csr_data      = '0;

   int mismatch_count;
   int outstanding_count;

   // Stimulus-side bookkeeping: which store entries hold a loaded pixel, and the side lengths
   // now in force, so that a compute is only ever issued once its four neighbours are loaded.
   bit pixel_loaded [brs_pkg::DEPTH];
   int source_now         = brs_pkg::SOURCE_SIDE_RESET;
   int dest_now           = brs_pkg::DEST_SIDE_RESET;
   int items_sent         = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_off_request   = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   bilinear_image_resampler dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   bilinear_image_resampler_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   // The receiver stalls at random at the rate of the current phase. When a hold-off is
   // requested it stalls without a break for a long stretch, counted here, so that the block
   // fills up and in turn stalls the sender.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
         end
      end
   end

   // The watchdog ends the run if no transaction moves on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL bilinear_image_resampler");
      $finish;
   end

   // Signals are read straight after a rising edge, before any register of that edge has
   // updated, so what is seen is what the edge itself sampled. A transaction offered at one
   // edge is therefore taken at the first later edge whose sampled stall is low.
   task automatic send_item(logic action, logic [brs_pkg::IDX_W-1:0] row,
                            logic [brs_pkg::IDX_W-1:0] col, logic [brs_pkg::PIX_W-1:0] pixel);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= action;
      req_row_index <= row;
      req_col_index <= col;
      req_pixel_in  <= pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (action == brs_pkg::ACT_LOAD) pixel_loaded[{row, col}] = 1'b1;
      items_sent++;
   endtask

   // Valid is lowered here and in the sender's idle steps, never in the step in which a new transaction is offered.
   task automatic release_requests();
      req_valid <= 1'b0;
   endtask

   task automatic load_pixel(int row, int col);
      send_item(brs_pkg::ACT_LOAD, brs_pkg::IDX_W'(row), brs_pkg::IDX_W'(col),
                brs_pkg::PIX_W'($urandom_range(0, 255)));
   endtask

   // A compute inside the destination is preceded by loads of whichever of its four source
   // neighbours have not been loaded yet; one outside the destination reads nothing.
   task automatic compute_pixel(int i, int j);
      int span, x, y;
      if (i < dest_now && j < dest_now) begin
         span = source_now - 1;
         x    = i * span / dest_now;
         y    = j * span / dest_now;
         for (int dx = 0; dx < 2; dx++)
            for (int dy = 0; dy < 2; dy++)
               if (!pixel_loaded[(x + dx) * brs_pkg::MAX_SIDE + y + dy])
                  load_pixel(x + dx, y + dy);
      end
      send_item(brs_pkg::ACT_COMPUTE, brs_pkg::IDX_W'(i), brs_pkg::IDX_W'(j),
                brs_pkg::PIX_W'($urandom));
   endtask

   // First lets the count take in the last accepted compute, then waits until every
   // expected result has come, then a little longer for work that yields no result.
   task automatic drain_results();
      release_requests();
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [brs_pkg::CSR_IDX_W-1:0] index,
                            logic [brs_pkg::SIDE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Writes both sides while the block is idle. Raw values outside the legal ranges are
   // saturated by the block, and the bookkeeping here follows the same rule.
   task automatic configure(int raw_source, int raw_dest);
      drain_results();
      csr_write(brs_pkg::CSR_SOURCE_SIDE, brs_pkg::SIDE_W'(raw_source));
      csr_write(brs_pkg::CSR_DEST_SIDE, brs_pkg::SIDE_W'(raw_dest));
      csr_valid <= 1'b0;
      source_now = (raw_source < int'(brs_pkg::SOURCE_SIDE_MIN)) ?
                   int'(brs_pkg::SOURCE_SIDE_MIN) :
                   (raw_source > brs_pkg::MAX_SIDE) ? brs_pkg::MAX_SIDE : raw_source;
      dest_now   = (raw_dest < int'(brs_pkg::DEST_SIDE_MIN)) ?
                   int'(brs_pkg::DEST_SIDE_MIN) :
                   (raw_dest > brs_pkg::MAX_SIDE) ? brs_pkg::MAX_SIDE : raw_dest;
   endtask

   // Mostly well-formed computes with their loads, then stray loads anywhere in the store,
   // and some computes that fall outside the destination in either coordinate.
   task automatic random_item();
      int pick, outside, other;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         compute_pixel($urandom_range(0, dest_now - 1), $urandom_range(0, dest_now - 1));
      end else if (pick < 85 || dest_now == brs_pkg::MAX_SIDE) begin
         load_pixel($urandom_range(0, brs_pkg::MAX_SIDE - 1),
                    $urandom_range(0, brs_pkg::MAX_SIDE - 1));
      end else begin
         outside = $urandom_range(dest_now, brs_pkg::MAX_SIDE - 1);
         other   = $urandom_range(0, brs_pkg::MAX_SIDE - 1);
         if ($urandom_range(0, 1)) compute_pixel(outside, other);
         else compute_pixel(other, outside);
      end
   endtask

   task automatic run_phase(int raw_source, int raw_dest, int idle_pct, int stall_pct,
                            pressure_type pressure);
      int first;
      bit pressed;
      configure(raw_source, raw_dest);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      first              = items_sent;
      pressed            = 1'b0;
      while (items_sent - first < PHASE_ITEMS) begin
         if (!pressed && items_sent - first >= PHASE_ITEMS / 2) begin
            pressed = 1'b1;
            if (pressure == PRESS_PAUSE) begin
               drain_results();
            end else if (pressure == PRESS_HOLD_OFF) begin
               // Keep offering computes while the receiver holds off, so the block backs up.
               hold_off_request = 1'b1;
               repeat (FILL_COMPUTES)
                  compute_pixel($urandom_range(0, dest_now - 1), $urandom_range(0, dest_now - 1));
            end
         end
         random_item();
      end
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Smallest source with a single destination pixel, plus writes to undecoded indexes,
      // which must leave both sides alone.
      configure(int'(brs_pkg::SOURCE_SIDE_MIN), int'(brs_pkg::DEST_SIDE_MIN));
      csr_write(CSR_SPARE_INDEX, brs_pkg::SIDE_W'(5));
      csr_write(CSR_TOP_INDEX, '1);
      csr_valid <= 1'b0;
      send_item(brs_pkg::ACT_LOAD, brs_pkg::IDX_W'(0), brs_pkg::IDX_W'(0), 8'h00);
      send_item(brs_pkg::ACT_LOAD, brs_pkg::IDX_W'(0), brs_pkg::IDX_W'(1), 8'hFF);
      send_item(brs_pkg::ACT_LOAD, brs_pkg::IDX_W'(1), brs_pkg::IDX_W'(0), 8'hFF);
      send_item(brs_pkg::ACT_LOAD, brs_pkg::IDX_W'(1), brs_pkg::IDX_W'(1), 8'h00);
      send_item(brs_pkg::ACT_COMPUTE, brs_pkg::IDX_W'(0), brs_pkg::IDX_W'(0), 8'hFF);
      // Computes outside the destination give no result.
      send_item(brs_pkg::ACT_COMPUTE, brs_pkg::IDX_W'(1), brs_pkg::IDX_W'(0), 8'h00);
      send_item(brs_pkg::ACT_COMPUTE, '1, '1, 8'hFF);

      // Out-of-range writes saturate: source to its minimum, destination to its maximum.
      // Full-scale pixels with the largest weights check that the sum does not wrap.
      configure(0, 255);
      send_item(brs_pkg::ACT_LOAD, brs_pkg::IDX_W'(0), brs_pkg::IDX_W'(0), 8'hFF);
      send_item(brs_pkg::ACT_LOAD, brs_pkg::IDX_W'(0), brs_pkg::IDX_W'(1), 8'hFF);
      send_item(brs_pkg::ACT_LOAD, brs_pkg::IDX_W'(1), brs_pkg::IDX_W'(0), 8'hFF);
      send_item(brs_pkg::ACT_LOAD, brs_pkg::IDX_W'(1), brs_pkg::IDX_W'(1), 8'hFF);
      send_item(brs_pkg::ACT_COMPUTE, '1, '1, 8'h00);
      send_item(brs_pkg::ACT_COMPUTE, brs_pkg::IDX_W'(64), brs_pkg::IDX_W'(0), 8'h00);
      send_item(brs_pkg::ACT_COMPUTE, brs_pkg::IDX_W'(0), '1, 8'h00);
      // A load beyond the source side is still stored.
      send_item(brs_pkg::ACT_LOAD, '1, '1, 8'hA5);

      // Saturation the other way round: largest source onto one destination pixel.
      configure(255, 0);
      compute_pixel(0, 0);

      // Both sides at their maximum, reaching the far corner of the store.
      configure(brs_pkg::MAX_SIDE, brs_pkg::MAX_SIDE);
      compute_pixel(brs_pkg::MAX_SIDE - 1, brs_pkg::MAX_SIDE - 1);

      run_phase(5, 9, 0, 0, PRESS_NONE);
      run_phase(brs_pkg::MAX_SIDE, brs_pkg::MAX_SIDE, 71, 0, PRESS_PAUSE);
      run_phase(2, 1, 0, 71, PRESS_NONE);
      run_phase(17, 4, 28, 28, PRESS_NONE);
      run_phase(100, 37, 0, 0, PRESS_HOLD_OFF);
      run_phase(brs_pkg::MAX_SIDE, 1, 71, 0, PRESS_NONE);
      run_phase($urandom_range(2, brs_pkg::MAX_SIDE), $urandom_range(1, brs_pkg::MAX_SIDE),
                0, 71, PRESS_NONE);
      run_phase(2, brs_pkg::MAX_SIDE, 28, 28, PRESS_NONE);
      run_phase($urandom_range(0, 255), $urandom_range(0, 255), 0, 0, PRESS_NONE);

      drain_results();
      if (mismatch_count == 0 && outstanding_count == 0)
         $display("PASS bilinear_image_resampler");
      else
         $display("FAIL bilinear_image_resampler");
      $finish;
   end

endmodule
